// File: rtl/core/vmoss_pkg.sv
// Package for the operand stack shuffle unit: sizes, command and status codes, entry type.
`default_nettype none

package vmoss_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_BITS  = 64;
    localparam int FIELD_VW    = 64;
    localparam int DEPTH_W     = 7;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int BANK_DEPTH  = (STACK_DEPTH + 1) / 2;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    typedef enum logic [3:0] {
        CMD_PUSH    = 4'd0,
        CMD_POP     = 4'd1,
        CMD_POP2    = 4'd2,
        CMD_DUP     = 4'd3,
        CMD_DUP_X1  = 4'd4,
        CMD_DUP_X2  = 4'd5,
        CMD_DUP2    = 4'd6,
        CMD_DUP2_X1 = 4'd7,
        CMD_DUP2_X2 = 4'd8,
        CMD_SWAP    = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_FORM  = 2'd3
    } status_t;

    typedef struct packed {
        logic                  wide;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/vm_operand_stack_shuffle_unit.sv
// Operand stack shuffle unit: top four entries in registers, the rest in two banked RAMs.
//
// One command is taken in every cycle (busy is never raised) and its result beat
// appears in the next cycle with done high for a single cycle; the receiver
// cannot stall. The four top entries sit in registers and the two entries below
// them are prefetched from an even and an odd RAM bank, each with one write and
// one registered read per cycle, so every command, including those that grow or
// shrink the stack by two, completes without a stall. No clearing pass after reset.
`default_nettype none

module vm_operand_stack_shuffle_unit
    import vmoss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [3:0]          cmd,
    input  wire logic [FIELD_VW-1:0] push_value,
    input  wire logic                push_wide,
    output logic                     done,
    output logic [FIELD_VW-1:0]      top_value,
    output logic                     top_wide,
    output logic [DEPTH_W-1:0]       depth,
    output logic [1:0]               status
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    entry_t              top_reg [4];
    entry_t              fwd_reg [2];
    logic [1:0]          fwd_sel_reg;
    logic [1:0]          fwd_sel_next;
    entry_t              rd_reg [2];
    entry_t              bank0_mem [BANK_DEPTH];
    entry_t              bank1_mem [BANK_DEPTH];

    logic                done_reg;
    logic [FIELD_VW-1:0] top_value_reg;
    logic                top_wide_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    status_t             status_reg;

    entry_t              ent [8];
    entry_t              nxt [6];
    entry_t              push_ent;
    logic [2:0]          k;
    logic [2:0]          m;
    logic [2:0]          k_eff;
    logic [2:0]          m_eff;
    logic                is_swap;
    logic                is_push;
    logic                ok;
    status_t             st;
    logic [CNT_W:0]      grown;
    logic                a1, a2, a3, a4;
    logic                grow1, grow2;
    logic [CNT_W-1:0]    e0, e1, r0, r1;
    logic [1:0]          wr_en;
    logic [BANK_AW-1:0]  wr_addr [2];
    entry_t              wr_data [2];
    logic [BANK_AW-1:0]  rd_addr [2];

    assign busy = 1'b0;

    assign push_ent.wide  = push_wide;
    assign push_ent.value = push_value[VALUE_BITS-1:0];

    always_comb
    begin
        ent[0] = top_reg[0];
        ent[1] = top_reg[1];
        ent[2] = top_reg[2];
        ent[3] = top_reg[3];
        ent[4] = fwd_sel_reg[0] ? fwd_reg[0] : rd_reg[~count_reg[0]];
        ent[5] = fwd_sel_reg[1] ? fwd_reg[1] : rd_reg[count_reg[0]];
        ent[6] = '0;
        ent[7] = '0;
    end

    assign a1 = (count_reg >= CNT_W'(1));
    assign a2 = (count_reg >= CNT_W'(2));
    assign a3 = (count_reg >= CNT_W'(3));
    assign a4 = (count_reg >= CNT_W'(4));

    // form selection, checked top down
    always_comb
    begin
        k       = '0;
        m       = '0;
        is_swap = 1'b0;
        is_push = 1'b0;
        st      = ST_OK;
        case (cmd)
            CMD_PUSH:
            begin
                is_push = 1'b1;
                m       = 3'd1;
            end
            CMD_POP:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) st = ST_FORM;
                else                  k  = 3'd1;
            end
            CMD_POP2:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) k  = 3'd1;
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide) st = ST_FORM;
                else                  k  = 3'd2;
            end
            CMD_DUP:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) st = ST_FORM;
                else
                begin
                    k = 3'd1;
                    m = 3'd2;
                end
            end
            CMD_DUP_X1:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) st = ST_FORM;
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide) st = ST_FORM;
                else
                begin
                    k = 3'd2;
                    m = 3'd3;
                end
            end
            CMD_DUP_X2:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) st = ST_FORM;
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide)
                begin
                    k = 3'd2;
                    m = 3'd3;
                end
                else if (!a3)         st = ST_UNDER;
                else if (ent[2].wide) st = ST_FORM;
                else
                begin
                    k = 3'd3;
                    m = 3'd4;
                end
            end
            CMD_DUP2:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide)
                begin
                    k = 3'd1;
                    m = 3'd2;
                end
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide) st = ST_FORM;
                else
                begin
                    k = 3'd2;
                    m = 3'd4;
                end
            end
            CMD_DUP2_X1:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide)
                begin
                    if (!a2)              st = ST_UNDER;
                    else if (ent[1].wide) st = ST_FORM;
                    else
                    begin
                        k = 3'd2;
                        m = 3'd3;
                    end
                end
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide) st = ST_FORM;
                else if (!a3)         st = ST_UNDER;
                else if (ent[2].wide) st = ST_FORM;
                else
                begin
                    k = 3'd3;
                    m = 3'd5;
                end
            end
            CMD_DUP2_X2:
            begin
                if (!a2)              st = ST_UNDER;
                else if (ent[0].wide)
                begin
                    if (ent[1].wide)
                    begin
                        k = 3'd2;
                        m = 3'd3;
                    end
                    else if (!a3)         st = ST_UNDER;
                    else if (ent[2].wide) st = ST_FORM;
                    else
                    begin
                        k = 3'd3;
                        m = 3'd4;
                    end
                end
                else if (ent[1].wide) st = ST_FORM;
                else if (!a3)         st = ST_UNDER;
                else if (ent[2].wide)
                begin
                    k = 3'd3;
                    m = 3'd5;
                end
                else if (!a4)         st = ST_UNDER;
                else if (ent[3].wide) st = ST_FORM;
                else
                begin
                    k = 3'd4;
                    m = 3'd6;
                end
            end
            CMD_SWAP:
            begin
                if (!a1)              st = ST_UNDER;
                else if (ent[0].wide) st = ST_FORM;
                else if (!a2)         st = ST_UNDER;
                else if (ent[1].wide) st = ST_FORM;
                else
                begin
                    k       = 3'd2;
                    m       = 3'd2;
                    is_swap = 1'b1;
                end
            end
            default:
            begin
                st = ST_FORM;
            end
        endcase
        grown = (CNT_W+1)'(count_reg) + (CNT_W+1)'(m) - (CNT_W+1)'(k);
        if (st == ST_OK && grown > (CNT_W+1)'(STACK_DEPTH))
            st = ST_OVER;
    end

    assign ok         = start && (st == ST_OK);
    assign k_eff      = ok ? k : 3'd0;
    assign m_eff      = ok ? m : 3'd0;
    assign count_next = ok ? grown[CNT_W-1:0] : count_reg;

    // new top six entries, index 0 is the new top
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            if (3'(j) < m_eff)
            begin
                if (is_push)
                    nxt[j] = push_ent;
                else if (is_swap)
                    nxt[j] = ent[3'd1 - 3'(j)];
                else if (3'(j) < k_eff)
                    nxt[j] = ent[3'(j)];
                else
                    nxt[j] = ent[3'(j) - k_eff];
            end
            else
                nxt[j] = ent[3'(j) - m_eff + k_eff];
        end
    end

    assign grow1 = (m_eff > k_eff);
    assign grow2 = (m_eff == k_eff + 3'd2);
    assign e0    = count_reg - CNT_W'(4);
    assign e1    = count_reg - CNT_W'(3);
    assign r0    = count_next - CNT_W'(5);
    assign r1    = count_next - CNT_W'(6);

    // spill of the entries pushed out below the top registers
    always_comb
    begin
        wr_en      = '0;
        wr_addr[0] = '0;
        wr_addr[1] = '0;
        wr_data[0] = '0;
        wr_data[1] = '0;
        if (grow1 && a4)
        begin
            wr_en[e0[0]]   = 1'b1;
            wr_addr[e0[0]] = e0[BANK_AW:1];
            wr_data[e0[0]] = grow2 ? nxt[5] : nxt[4];
        end
        if (grow2 && a3)
        begin
            wr_en[e1[0]]   = 1'b1;
            wr_addr[e1[0]] = e1[BANK_AW:1];
            wr_data[e1[0]] = nxt[4];
        end
    end

    always_comb
    begin
        rd_addr[0]     = '0;
        rd_addr[1]     = '0;
        rd_addr[r0[0]] = r0[BANK_AW:1];
        rd_addr[r1[0]] = r1[BANK_AW:1];
    end

    // entries below the top registers come from the RAM unless just produced
    assign fwd_sel_next[0] = (4'(m_eff) + 4'd1 >= 4'(k_eff));
    assign fwd_sel_next[1] = (m_eff >= k_eff);

    always_ff @(posedge clk)
    begin
        if (wr_en[0])
            bank0_mem[wr_addr[0]] <= wr_data[0];
        rd_reg[0] <= bank0_mem[rd_addr[0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en[1])
            bank1_mem[wr_addr[1]] <= wr_data[1];
        rd_reg[1] <= bank1_mem[rd_addr[1]];
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
            top_reg[j] <= nxt[j];
        fwd_reg[0]    <= nxt[4];
        fwd_reg[1]    <= nxt[5];
        fwd_sel_reg   <= fwd_sel_next;
        top_value_reg <= (count_next != '0) ? FIELD_VW'(nxt[0].value) : '0;
        top_wide_reg  <= (count_next != '0) ? nxt[0].wide : 1'b0;
        depth_reg     <= DEPTH_W'(count_next);
        status_reg    <= st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    assign done      = done_reg;
    assign top_value = top_value_reg;
    assign top_wide  = top_wide_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_depth_match: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> depth == DEPTH_W'(count_reg))
        else $error("reported depth differs from stack count");

    a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        start && (st != ST_OK) |=> count_reg == $past(count_reg))
        else $error("failed command changed the stack");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> count_reg == $past(count_reg))
        else $error("stack count moved without a command");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (depth == '0) |-> (top_value == '0) && !top_wide)
        else $error("empty stack reports a top entry");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for vm_operand_stack_shuffle_unit: directed table plus random commands, scoreboarded.
module tb;
    import vmoss_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_BEATS = 1100;
    localparam logic [3:0]  OP_UNKNOWN = 4'd15;

    typedef struct packed {
        logic [FIELD_VW-1:0] value;
        logic                wide;
        logic [DEPTH_W-1:0]  depth;
        status_t             st;
    } top_report_t;

    localparam top_report_t NO_CHECK = '{value: '0, wide: 1'b0, depth: '0, st: ST_OK};
    localparam top_report_t EMPTY_UNDER = '{value: '0, wide: 1'b0, depth: '0, st: ST_UNDER};
    localparam top_report_t EMPTY_FORM = '{value: '0, wide: 1'b0, depth: '0, st: ST_FORM};

    typedef struct {
        logic [3:0]          op;
        logic [FIELD_VW-1:0] value;
        logic                wide;
        bit                  typed;
        top_report_t         want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [3:0]          cmd = '0;
    logic [FIELD_VW-1:0] push_value = '0;
    logic                push_wide = 1'b0;
    logic                busy;
    logic                done;
    logic [FIELD_VW-1:0] top_value;
    logic                top_wide;
    logic [DEPTH_W-1:0]  depth;
    logic [1:0]          status;

    entry_t        model_stack [STACK_DEPTH];
    int            model_count = 0;
    int            shuffle_order [$];
    top_report_t   expected_tops [$];
    stim_row_t     dir_rows [$];
    int            fail_count = 0;
    int            cycle_count = 0;

    vm_operand_stack_shuffle_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .push_value (push_value),
        .push_wide  (push_wide),
        .done       (done),
        .top_value  (top_value),
        .top_wide   (top_wide),
        .depth      (depth),
        .status     (status)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    function automatic logic wide_at(input int i);
        return model_stack[model_count - 1 - i].wide;
    endfunction

    function automatic bit short_of(input int n);
        return model_count < n;
    endfunction

    // Picks the form from the wide flags; k = entries consumed, shuffle_order = new top slots.
    function automatic status_t plan_shuffle(input logic [3:0] op, output int k);
        k = 0;
        shuffle_order.delete();
        case (op)
            CMD_POP:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0)) return ST_FORM;
                k = 1;
            end
            CMD_POP2:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0))
                begin
                    k = 1;
                    return ST_OK;
                end
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1)) return ST_FORM;
                k = 2;
            end
            CMD_DUP:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0)) return ST_FORM;
                k = 1;
                shuffle_order = {0, 0};
            end
            CMD_DUP_X1:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0)) return ST_FORM;
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1)) return ST_FORM;
                k = 2;
                shuffle_order = {0, 1, 0};
            end
            CMD_DUP_X2:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0)) return ST_FORM;
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1))
                begin
                    k = 2;
                    shuffle_order = {0, 1, 0};
                    return ST_OK;
                end
                if (short_of(3)) return ST_UNDER;
                if (wide_at(2)) return ST_FORM;
                k = 3;
                shuffle_order = {0, 2, 1, 0};
            end
            CMD_DUP2:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0))
                begin
                    k = 1;
                    shuffle_order = {0, 0};
                    return ST_OK;
                end
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1)) return ST_FORM;
                k = 2;
                shuffle_order = {1, 0, 1, 0};
            end
            CMD_DUP2_X1:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0))
                begin
                    if (short_of(2)) return ST_UNDER;
                    if (wide_at(1)) return ST_FORM;
                    k = 2;
                    shuffle_order = {0, 1, 0};
                    return ST_OK;
                end
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1)) return ST_FORM;
                if (short_of(3)) return ST_UNDER;
                if (wide_at(2)) return ST_FORM;
                k = 3;
                shuffle_order = {1, 0, 2, 1, 0};
            end
            CMD_DUP2_X2:
            begin
                if (short_of(2)) return ST_UNDER;
                if (wide_at(0))
                begin
                    if (wide_at(1))
                    begin
                        k = 2;
                        shuffle_order = {0, 1, 0};
                        return ST_OK;
                    end
                    if (short_of(3)) return ST_UNDER;
                    if (wide_at(2)) return ST_FORM;
                    k = 3;
                    shuffle_order = {0, 2, 1, 0};
                    return ST_OK;
                end
                if (wide_at(1)) return ST_FORM;
                if (short_of(3)) return ST_UNDER;
                if (wide_at(2))
                begin
                    k = 3;
                    shuffle_order = {1, 0, 2, 1, 0};
                    return ST_OK;
                end
                if (short_of(4)) return ST_UNDER;
                if (wide_at(3)) return ST_FORM;
                k = 4;
                shuffle_order = {1, 0, 3, 2, 1, 0};
            end
            CMD_SWAP:
            begin
                if (short_of(1)) return ST_UNDER;
                if (wide_at(0)) return ST_FORM;
                if (short_of(2)) return ST_UNDER;
                if (wide_at(1)) return ST_FORM;
                k = 2;
                shuffle_order = {0, 1};
            end
            default:
                return ST_FORM;
        endcase
        return ST_OK;
    endfunction

    function automatic top_report_t stack_step(input logic [3:0] op,
                                               input logic [FIELD_VW-1:0] v,
                                               input logic w);
        top_report_t rep;
        status_t     st;
        int          k;
        entry_t      taken [4];
        st = ST_OK;
        if (op == CMD_PUSH)
        begin
            if (model_count >= STACK_DEPTH)
                st = ST_OVER;
            else
            begin
                model_stack[model_count] = '{wide: w, value: v[VALUE_BITS-1:0]};
                model_count++;
            end
        end
        else
        begin
            st = plan_shuffle(op, k);
            if (st == ST_OK && model_count - k + shuffle_order.size() > STACK_DEPTH)
                st = ST_OVER;
            if (st == ST_OK)
            begin
                for (int i = 0; i < k; i++)
                    taken[i] = model_stack[model_count - 1 - i];
                model_count -= k;
                foreach (shuffle_order[j])
                begin
                    model_stack[model_count] = taken[shuffle_order[j]];
                    model_count++;
                end
            end
        end
        if (model_count > 0)
        begin
            rep.value = FIELD_VW'(model_stack[model_count - 1].value);
            rep.wide  = model_stack[model_count - 1].wide;
        end
        else
        begin
            rep.value = '0;
            rep.wide  = 1'b0;
        end
        rep.depth = DEPTH_W'(model_count);
        rep.st    = st;
        return rep;
    endfunction

    task automatic issue(input stim_row_t row, input bit may_idle);
        top_report_t pred;
        start      <= 1'b1;
        cmd        <= row.op;
        push_value <= row.value;
        push_wide  <= row.wide;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = stack_step(row.op, row.value, row.wide);
        expected_tops.push_back(row.typed ? row.want : pred);
        if (may_idle && $urandom_range(99) < 13)
        begin
            start      <= 1'b0;
            cmd        <= 4'($urandom);
            push_value <= {$urandom, $urandom};
            push_wide  <= 1'($urandom);
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_tops.size() == 0)
            begin
                $error("unexpected result beat: top_value %0h depth %0d", top_value, depth);
                fail_count++;
            end
            else
            begin
                top_report_t exp_top;
                exp_top = expected_tops.pop_front();
                if (top_value !== exp_top.value)
                begin
                    $error("top_value: expected %0h, got %0h", exp_top.value, top_value);
                    fail_count++;
                end
                if (top_wide !== exp_top.wide)
                begin
                    $error("top_wide: expected %0d, got %0d", exp_top.wide, top_wide);
                    fail_count++;
                end
                if (depth !== exp_top.depth)
                begin
                    $error("depth: expected %0d, got %0d", exp_top.depth, depth);
                    fail_count++;
                end
                if (status !== exp_top.st)
                begin
                    $error("status: expected %0d, got %0d", exp_top.st, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        push_pct;
        int        wide_pct;
        int        pick;
        int        spin;
        dir_rows.push_back('{op: CMD_POP, value: '0, wide: 1'b0, typed: 1'b1, want: EMPTY_UNDER});
        dir_rows.push_back('{op: CMD_POP2, value: '1, wide: 1'b1, typed: 1'b1, want: EMPTY_UNDER});
        dir_rows.push_back('{op: CMD_DUP2_X2, value: '0, wide: 1'b0, typed: 1'b1,
                             want: EMPTY_UNDER});
        dir_rows.push_back('{op: OP_UNKNOWN, value: '0, wide: 1'b0, typed: 1'b1, want: EMPTY_FORM});
        dir_rows.push_back('{op: CMD_PUSH, value: '1, wide: 1'b1, typed: 1'b1,
                             want: '{value: '1, wide: 1'b1, depth: 7'd1, st: ST_OK}});
        dir_rows.push_back('{op: CMD_POP, value: '0, wide: 1'b0, typed: 1'b1,
                             want: '{value: '1, wide: 1'b1, depth: 7'd1, st: ST_FORM}});
        dir_rows.push_back('{op: CMD_SWAP, value: '0, wide: 1'b0, typed: 1'b1,
                             want: '{value: '1, wide: 1'b1, depth: 7'd1, st: ST_FORM}});
        dir_rows.push_back('{op: CMD_DUP2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_POP2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_PUSH, value: '0, wide: 1'b0, typed: 1'b1,
                             want: '{value: '0, wide: 1'b0, depth: 7'd2, st: ST_OK}});
        dir_rows.push_back('{op: CMD_DUP2_X1, value: '1, wide: 1'b1, typed: 1'b1,
                             want: '{value: '0, wide: 1'b0, depth: 7'd2, st: ST_FORM}});
        dir_rows.push_back('{op: CMD_PUSH, value: 64'h8000_0000_0000_0001, wide: 1'b0,
                             typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP_X2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_PUSH, value: 64'h5, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP2_X2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP_X1, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_SWAP, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP2_X2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP_X2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_POP2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_PUSH, value: 64'h7b, wide: 1'b1, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP2_X1, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});
        dir_rows.push_back('{op: CMD_DUP2_X2, value: '0, wide: 1'b0, typed: 1'b0, want: NO_CHECK});

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue(dir_rows[i], 1'b1);

        push_pct = 50;
        wide_pct = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // new fill/drain mix every 128 beats so the stack sweeps empty to full
            if (n % 128 == 0)
            begin
                case ($urandom_range(3))
                    0: push_pct = 15;
                    1: push_pct = 35;
                    2: push_pct = 60;
                    default: push_pct = 85;
                endcase
                case ($urandom_range(2))
                    0: wide_pct = 0;
                    1: wide_pct = 15;
                    default: wide_pct = 50;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < push_pct)
                row.op = CMD_PUSH;
            else if (pick >= 97)
                row.op = 4'($urandom_range(10, 15));
            else
                row.op = 4'($urandom_range(1, 9));
            row.value = {$urandom, $urandom};
            row.wide  = ($urandom_range(99) < wide_pct);
            row.typed = 1'b0;
            row.want  = NO_CHECK;
            issue(row, !(n >= 500 && n < 750));
        end
        start <= 1'b0;

        spin = 0;
        while (expected_tops.size() > 0 && spin < 100)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (4)
            @(posedge clk);
        if (expected_tops.size() > 0)
        begin
            $error("%0d result beats never arrived", expected_tops.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
